@@ rtl/core/infix_to_postfix_converter_top_assert.svh @@
// Assertion macros for the infix-to-postfix converter sequencer.
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define ITP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itp: same-cycle property violated");
// Next-cycle implication, checked at every rising edge outside reset.
`define ITP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itp: next-cycle property violated");
`else
`define ITP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ITP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/itp_pkg.sv @@
// Types, character constants and operator helpers for the infix-to-postfix converter.
package itp_pkg;

  // ASCII characters recognised by the converter.
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Operator codes as held on the stack.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_code_t;

  // One result word handed from the sequencer to the output register.
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       last;
    logic       ovf;
  } out_word_t;

  function automatic logic is_numeral(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

  function automatic logic is_op(input logic [7:0] ch);
    return (ch == CH_ADD) || (ch == CH_SUB) || (ch == CH_MUL) || (ch == CH_DIV);
  endfunction

  function automatic op_code_t op_code(input logic [7:0] ch);
    op_code_t c;
    case (ch)
      CH_SUB:  c = OP_SUB;
      CH_MUL:  c = OP_MUL;
      CH_DIV:  c = OP_DIV;
      default: c = OP_ADD;
    endcase
    return c;
  endfunction

  // Multiplicative operators rank above additive ones.
  function automatic logic op_rank(input op_code_t c);
    return (c == OP_MUL) || (c == OP_DIV);
  endfunction

  function automatic logic [7:0] op_char(input op_code_t c);
    logic [7:0] ch;
    case (c)
      OP_ADD:  ch = CH_ADD;
      OP_SUB:  ch = CH_SUB;
      OP_MUL:  ch = CH_MUL;
      OP_DIV:  ch = CH_DIV;
      default: ch = CH_ADD;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/itp_stack_mem.sv @@
// Operator stack storage: one write port and one registered read port.
module itp_stack_mem #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  itp_pkg::op_code_t        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output itp_pkg::op_code_t        rd_data
);

  itp_pkg::op_code_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/itp_out_reg.sv @@
// Output register for the master-side stream of postfix characters.
module itp_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  itp_pkg::out_word_t  word,
  output logic                free,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,  // out_char
  output logic [1:0]          m_tuser,  // [0] char_valid, [1] stack_overflowed
  output logic                m_tlast   // last_of_expression
);

  itp_pkg::out_word_t held;

  // The slot can take a new word when empty or when its word leaves now.
  assign free = !m_tvalid || m_tready;

  // Valid flag under reset, payload without.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load) begin
      held <= word;
    end
  end

  assign m_tdata = held.out_char;
  assign m_tuser = {held.ovf, held.char_valid};
  assign m_tlast = held.last;

endmodule

@@ rtl/core/itp_ctrl.sv @@
// Sequencer: classifies characters, pops and pushes the stack and emits words.
`include "infix_to_postfix_converter_top_assert.svh"

module itp_ctrl #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,
  input  logic                           s_tlast,
  input  logic                           out_free,
  output logic                           out_load,
  output itp_pkg::out_word_t             out_word,
  output logic                           wr_en,
  output logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
  output itp_pkg::op_code_t              wr_data,
  output logic                           rd_en,
  output logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
  input  itp_pkg::op_code_t              rd_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_FLUSH
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic              ovf, ovf_next;
  logic              top_ok, top_ok_next;
  logic              last_seen, last_seen_next;
  itp_pkg::op_code_t code, code_next;

  logic          accept;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] count_m2;
  logic          pop_now;

  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign count_m1 = count - CW'(1);
  assign count_m2 = count - CW'(2);

  // Next-state logic: one stack access and at most one word per cycle.
  always_comb begin
    state_next     = state;
    count_next     = count;
    ovf_next       = ovf;
    top_ok_next    = top_ok;
    last_seen_next = last_seen;
    code_next      = code;
    rd_en          = 1'b0;
    rd_addr        = count_m1[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = count[AW-1:0];
    wr_data        = code;
    out_load       = 1'b0;
    out_word       = '{out_char: 8'd0, char_valid: 1'b0, last: 1'b0, ovf: ovf};
    pop_now        = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          // Fetch the top entry early in case an operator or flush follows.
          rd_en          = (count != '0);
          top_ok_next    = (count != '0);
          code_next      = itp_pkg::op_code(s_tdata);
          last_seen_next = s_tlast;
          if (itp_pkg::is_numeral(s_tdata)) begin
            out_load            = 1'b1;
            out_word.out_char   = s_tdata;
            out_word.char_valid = 1'b1;
            out_word.last       = s_tlast && (count == '0);
          end
          if (itp_pkg::is_op(s_tdata)) begin
            state_next = S_OP;
          end else if (s_tlast) begin
            if (count == '0) begin
              // Empty stack: end here, with a blank end marker unless the last character is a digit.
              if (!itp_pkg::is_numeral(s_tdata)) begin
                out_load      = 1'b1;
                out_word.last = 1'b1;
              end
              ovf_next = 1'b0;
            end else begin
              state_next = S_FLUSH;
            end
          end
        end
      end

      S_OP: begin
        if ((count == '0) ||
            (top_ok && (itp_pkg::op_rank(rd_data) < itp_pkg::op_rank(code)))) begin
          // Nothing left to pop: push, or drop on a full stack.
          if (count < CW'(STACK_DEPTH)) begin
            wr_en      = 1'b1;
            count_next = count + CW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          top_ok_next = 1'b0;
          state_next  = last_seen ? S_FLUSH : S_IDLE;
        end else if (!top_ok) begin
          rd_en       = 1'b1;
          top_ok_next = 1'b1;
        end else if (out_free) begin
          // Pop an operator of equal or higher rank and fetch the one below.
          pop_now             = 1'b1;
          out_load            = 1'b1;
          out_word.out_char   = itp_pkg::op_char(rd_data);
          out_word.char_valid = 1'b1;
          count_next          = count_m1;
          rd_en               = (count > CW'(1));
          rd_addr             = count_m2[AW-1:0];
          top_ok_next         = (count > CW'(1));
        end
      end

      S_FLUSH: begin
        if (!top_ok) begin
          rd_en       = 1'b1;
          top_ok_next = 1'b1;
        end else if (out_free) begin
          // Emit the top entry; the bottom one closes the expression.
          pop_now             = 1'b1;
          out_load            = 1'b1;
          out_word.out_char   = itp_pkg::op_char(rd_data);
          out_word.char_valid = 1'b1;
          out_word.last       = (count == CW'(1));
          count_next          = count_m1;
          if (count > CW'(1)) begin
            rd_en       = 1'b1;
            rd_addr     = count_m2[AW-1:0];
            top_ok_next = 1'b1;
          end else begin
            top_ok_next = 1'b0;
            ovf_next    = 1'b0;
            state_next  = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      top_ok    <= 1'b0;
      last_seen <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ovf       <= ovf_next;
      top_ok    <= top_ok_next;
      last_seen <= last_seen_next;
    end
    code <= code_next;
  end

  // The stack never holds more entries than it has.
  `ITP_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CW'(STACK_DEPTH))
  // A word is only handed over when the output slot can take it.
  `ITP_ASSERT_IMP(a_load_free, clk, rst, out_load, out_free)
  // A pop only uses read data that belongs to the current top entry.
  `ITP_ASSERT_IMP(a_pop_top, clk, rst, pop_now, top_ok && (count != '0))
  // After the final word of an expression the stack and error flag are clear.
  `ITP_ASSERT_NXT(a_end_clear, clk, rst, out_load && out_word.last,
                  (count == '0) && !ovf && (state == S_IDLE))

endmodule

@@ rtl/core/infix_to_postfix_converter_top.sv @@
// Top level of the shunting-yard infix-to-postfix converter.
//
// Input stream: one ASCII character per word on s_tdata, s_tlast marking the
// last character of an expression. Digits pass straight through; + - * / go
// onto an operator stack after popping every stacked operator of equal or
// higher rank; other characters are dropped. At the last character the stack
// is flushed top first and the final word carries m_tlast. If an expression
// yields nothing, a blank word (m_tuser[0] low) with m_tlast is sent.
// m_tuser[1] shows the sticky overflow flag, set when an operator is dropped
// on a full stack and cleared at the end of each expression.
// Timing: an operator first pops entries one at a time and then pushes, and the
// end of an expression flushes entries one at a time; the registered read
// port of the stack memory sets this, each pop issuing the read of the entry
// below it. A word reaches m_tvalid in the cycle after it is formed.
// Reset (rst, synchronous) empties the stack and the output register; no
// clearing pass is needed. When m_tready is low, the held word waits, the
// sequencer stalls and s_tready drops until the output register is free.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // symbol
  input  logic       s_tlast,   // end_of_expression
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_char
  output logic [1:0] m_tuser,   // [0] char_valid, [1] stack_overflowed
  output logic       m_tlast    // last_of_expression
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic               out_free;
  logic               out_load;
  itp_pkg::out_word_t out_word;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  itp_pkg::op_code_t  wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  itp_pkg::op_code_t  rd_data;

  // Sequencer.
  itp_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .out_free (out_free),
    .out_load (out_load),
    .out_word (out_word),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // Operator stack memory.
  itp_stack_mem #(
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register.
  itp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .word     (out_word),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
